>>> src/pgkd_pkg.sv
// shared types, constants and the arc tangent table of the path gap and kink detector
`timescale 1ns / 1ps
package pgkd_pkg;

    localparam int COORD_W = 32;
    localparam int DELTA_W = 33;
    localparam int LEN_W   = 34;
    localparam int RAD_W   = 68;
    localparam int ANG_W   = 16;
    localparam int CONF_W  = 17;
    localparam int ENTRY_W = 3 * DELTA_W + COORD_W + LEN_W;
    localparam int ATAN_STEPS = 22;

    localparam logic [CONF_W-1:0] GAP_CONF  = 17'd58982;
    localparam logic [CONF_W-1:0] CONF_ONE  = 17'd65536;
    localparam logic [ANG_W-1:0]  ANGLE_MAX = 16'd46080;
    localparam logic [27:0]       Z_QUARTER = 28'd5898240;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_KINK_THR   = 2'd0;
    localparam logic [1:0] CFG_GAP_RATIO  = 2'd1;
    localparam logic [1:0] CFG_MIN_POINTS = 2'd2;

    localparam logic [15:0] KINK_THR_RST   = 16'd1280;
    localparam logic [15:0] GAP_RATIO_RST  = 16'd1280;
    localparam logic [8:0]  MIN_POINTS_RST = 9'd8;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic sq;
        logic root_len;
        logic store;
        logic eval_init;
        logic med_start;
        logic med_scan;
        logic med_bit;
        logic thr_mul;
        logic idx_zero;
        logic idx_one;
        logic idx_inc;
        logic gap_take;
        logic red_load;
        logic red_run;
        logic base_take;
        logic kmul;
        logic kdiff;
        logic ksq;
        logic root_cross;
        logic cordic_init;
        logic cordic_run;
        logic kink_eval;
        logic conf_fixed;
        logic div_go;
        logic emit;
        logic path_clr;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic seg;
        logic last;
        logic root_busy;
        logic eval_ok;
        logic scan_done;
        logic med_last;
        logic gap_hit;
        logic gap_tnz;
        logic idx_last;
        logic len_zero;
        logic red_busy;
        logic cordic_busy;
        logic atime_set;
        logic need_div;
        logic div_busy;
        logic out_free;
    } sts_t;

    // atan(2^-i) in degrees times 65536, rounded to nearest
    function automatic logic [21:0] atan_deg(input logic [4:0] i);
        logic [21:0] r;
        case (i)
            5'd0:  r = 22'd2949120;
            5'd1:  r = 22'd1740967;
            5'd2:  r = 22'd919879;
            5'd3:  r = 22'd466945;
            5'd4:  r = 22'd234379;
            5'd5:  r = 22'd117304;
            5'd6:  r = 22'd58666;
            5'd7:  r = 22'd29335;
            5'd8:  r = 22'd14668;
            5'd9:  r = 22'd7334;
            5'd10: r = 22'd3667;
            5'd11: r = 22'd1833;
            5'd12: r = 22'd917;
            5'd13: r = 22'd458;
            5'd14: r = 22'd229;
            5'd15: r = 22'd115;
            5'd16: r = 22'd57;
            5'd17: r = 22'd29;
            5'd18: r = 22'd14;
            5'd19: r = 22'd7;
            5'd20: r = 22'd4;
            5'd21: r = 22'd2;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage

>>> src/pgkd_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module pgkd_ram #(
    parameter int W = 8,
    parameter int D = 4
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);
    logic [W-1:0] mem [D];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> src/pgkd_ctrl.sv
// sequencing state machine of the path gap and kink detector
`timescale 1ns / 1ps
module pgkd_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  pgkd_pkg::sts_t sts,
    output pgkd_pkg::cmd_t cmd
);
    typedef enum logic [27:0] {
        S_IDLE    = 28'b1 << 0,
        S_PT      = 28'b1 << 1,
        S_LGO     = 28'b1 << 2,
        S_LROOT   = 28'b1 << 3,
        S_STORE   = 28'b1 << 4,
        S_CHECK   = 28'b1 << 5,
        S_MSTART  = 28'b1 << 6,
        S_MSCAN   = 28'b1 << 7,
        S_MBIT    = 28'b1 << 8,
        S_THR     = 28'b1 << 9,
        S_GRD     = 28'b1 << 10,
        S_GCHK    = 28'b1 << 11,
        S_BRD     = 28'b1 << 12,
        S_BLD     = 28'b1 << 13,
        S_BRED    = 28'b1 << 14,
        S_KRD     = 28'b1 << 15,
        S_KLD     = 28'b1 << 16,
        S_KRED    = 28'b1 << 17,
        S_KDIFF   = 28'b1 << 18,
        S_KSQ     = 28'b1 << 19,
        S_KSUM    = 28'b1 << 20,
        S_KROOT   = 28'b1 << 21,
        S_KCOR    = 28'b1 << 22,
        S_KEVAL   = 28'b1 << 23,
        S_KNEXT   = 28'b1 << 24,
        S_FIN     = 28'b1 << 25,
        S_DIV     = 28'b1 << 26,
        S_EMIT    = 28'b1 << 27
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_PT;
                end
            end
            S_PT: begin
                cmd.sq = 1'b1;
                if (sts.seg) begin
                    state_next = S_LGO;
                end else if (sts.last) begin
                    state_next = S_CHECK;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_LGO: begin
                cmd.root_len = 1'b1;
                state_next   = S_LROOT;
            end
            S_LROOT: begin
                if (!sts.root_busy) begin
                    state_next = S_STORE;
                end
            end
            S_STORE: begin
                cmd.store  = 1'b1;
                state_next = sts.last ? S_CHECK : S_IDLE;
            end
            S_CHECK: begin
                cmd.eval_init = 1'b1;
                state_next    = sts.eval_ok ? S_MSTART : S_FIN;
            end
            // median by one bit of the length per scan
            S_MSTART: begin
                cmd.med_start = 1'b1;
                state_next    = S_MSCAN;
            end
            S_MSCAN: begin
                if (sts.scan_done) begin
                    state_next = S_MBIT;
                end else begin
                    cmd.med_scan = 1'b1;
                end
            end
            S_MBIT: begin
                cmd.med_bit = 1'b1;
                state_next  = sts.med_last ? S_THR : S_MSTART;
            end
            // gap scan
            S_THR: begin
                cmd.thr_mul = 1'b1;
                cmd.idx_one = 1'b1;
                state_next  = S_GRD;
            end
            S_GRD: begin
                state_next = S_GCHK;
            end
            S_GCHK: begin
                if (sts.gap_hit) begin
                    cmd.gap_take = 1'b1;
                    cmd.idx_zero = 1'b1;
                    state_next   = sts.gap_tnz ? S_FIN : S_BRD;
                end else if (sts.idx_last) begin
                    cmd.idx_zero = 1'b1;
                    state_next   = S_BRD;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_GRD;
                end
            end
            // base segment
            S_BRD: begin
                state_next = S_BLD;
            end
            S_BLD: begin
                cmd.red_load = 1'b1;
                state_next   = S_BRED;
            end
            S_BRED: begin
                if (sts.red_busy) begin
                    cmd.red_run = 1'b1;
                end else begin
                    cmd.base_take = 1'b1;
                    cmd.idx_one   = 1'b1;
                    state_next    = S_KRD;
                end
            end
            // kink scan
            S_KRD: begin
                state_next = S_KLD;
            end
            S_KLD: begin
                if (sts.len_zero) begin
                    state_next = S_KNEXT;
                end else begin
                    cmd.red_load = 1'b1;
                    state_next   = S_KRED;
                end
            end
            S_KRED: begin
                if (sts.red_busy) begin
                    cmd.red_run = 1'b1;
                end else begin
                    cmd.kmul   = 1'b1;
                    state_next = S_KDIFF;
                end
            end
            S_KDIFF: begin
                cmd.kdiff  = 1'b1;
                state_next = S_KSQ;
            end
            S_KSQ: begin
                cmd.ksq    = 1'b1;
                state_next = S_KSUM;
            end
            S_KSUM: begin
                cmd.root_cross = 1'b1;
                state_next     = S_KROOT;
            end
            S_KROOT: begin
                if (!sts.root_busy) begin
                    cmd.cordic_init = 1'b1;
                    state_next      = S_KCOR;
                end
            end
            S_KCOR: begin
                if (sts.cordic_busy) begin
                    cmd.cordic_run = 1'b1;
                end else begin
                    state_next = S_KEVAL;
                end
            end
            S_KEVAL: begin
                cmd.kink_eval = 1'b1;
                state_next    = S_KNEXT;
            end
            S_KNEXT: begin
                if (sts.atime_set || sts.idx_last) begin
                    state_next = S_FIN;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_KRD;
                end
            end
            // confidence and result
            S_FIN: begin
                cmd.conf_fixed = 1'b1;
                if (sts.need_div) begin
                    cmd.div_go = 1'b1;
                    state_next = S_DIV;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_DIV: begin
                if (!sts.div_busy) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.path_clr = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

>>> src/pgkd_dp.sv
// datapath: path state, segment store, square root, median, cordic and divider
`timescale 1ns / 1ps
module pgkd_dp #(
    parameter int MAX_POINTS = 256
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  pgkd_pkg::cmd_t cmd,
    output pgkd_pkg::sts_t sts,
    input  logic [127:0]   s_tdata,
    input  logic           s_tlast,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_addr,
    input  logic [15:0]    cfg_wdata,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [71:0]    m_tdata,
    output logic [1:0]     m_tuser
);
    localparam int SEG_CAP = MAX_POINTS - 1;
    localparam int AW      = $clog2(SEG_CAP);
    localparam int CW      = $clog2(MAX_POINTS + 1);
    localparam int MW      = (CW > 9) ? CW : 9;
    localparam int LW      = pgkd_pkg::LEN_W;
    localparam int DW      = pgkd_pkg::DELTA_W;

    // configuration registers
    logic [15:0] kthr_reg, gratio_reg;
    logic [8:0]  minp_reg;

    // path state
    logic signed [31:0] prev_x_reg, prev_y_reg, prev_z_reg, prev_t_reg;
    logic               have_prev_reg;
    logic [CW-1:0]      pc_reg, nseg_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, dz_reg;
    logic [31:0]        ptime_reg;
    logic               seg_reg, last_reg;
    logic [64:0]        sq_reg [3];
    logic [LW-1:0]      len0_reg;

    // square root unit
    logic [pgkd_pkg::RAD_W-1:0] rad_reg;
    logic [35:0]        rem_reg;
    logic [LW-1:0]      root_reg;
    logic [5:0]         rcnt_reg;

    // median search
    logic [CW-1:0]      idx_reg, cnt_reg, rank_reg;
    logic               vld_reg;
    logic [LW-1:0]      pref_reg, mask_reg, bsel_reg;
    logic [49:0]        thp_reg;

    // anomaly held so far
    logic signed [31:0] atime_reg;
    logic               kind_reg;
    logic [15:0]        ang_reg;
    logic [16:0]        conf_reg;

    // vector reduction and products
    logic [DW-1:0]      red_mag_reg [3];
    logic               red_neg_reg [3];
    logic signed [15:0] base_reg [3];
    logic signed [31:0] pd_reg [3];
    logic signed [31:0] pcr_reg [6];
    logic signed [33:0] dot_reg;
    logic signed [32:0] cr_reg [3];
    logic [64:0]        crsq_reg [3];

    // cordic
    logic signed [35:0] cx_reg, cy_reg;
    logic signed [27:0] cz_reg;
    logic [4:0]         ci_reg;

    // divider
    logic [35:0]        dnum_reg;
    logic [21:0]        drem_reg;
    logic [19:0]        dden_reg;
    logic [5:0]         dcnt_reg;

    // output register
    logic               mv_reg;
    logic [71:0]        mdata_reg;
    logic [1:0]         muser_reg;

    // ram
    logic [pgkd_pkg::ENTRY_W-1:0] rdata;
    logic [LW-1:0]      rd_len;
    logic [31:0]        rd_time;
    logic signed [DW-1:0] rd_d [3];

    pgkd_ram #(.W(pgkd_pkg::ENTRY_W), .D(SEG_CAP)) u_seg_ram (
        .aclk  (aclk),
        .we    (cmd.store),
        .waddr (nseg_reg[AW-1:0]),
        .wdata ({root_reg, ptime_reg, dz_reg, dy_reg, dx_reg}),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rdata)
    );

    assign rd_d[0] = $signed(rdata[DW-1:0]);
    assign rd_d[1] = $signed(rdata[2*DW-1:DW]);
    assign rd_d[2] = $signed(rdata[3*DW-1:2*DW]);
    assign rd_time = rdata[3*DW+31:3*DW];
    assign rd_len  = rdata[3*DW+32+LW-1:3*DW+32];

    // incoming point and segment deltas
    logic signed [31:0] in_x, in_y, in_z, in_t;
    logic signed [32:0] dt;
    logic               room;
    assign in_x = $signed(s_tdata[31:0]);
    assign in_y = $signed(s_tdata[63:32]);
    assign in_z = $signed(s_tdata[95:64]);
    assign in_t = $signed(s_tdata[127:96]);
    assign dt   = $signed({in_t[31], in_t}) - $signed({prev_t_reg[31], prev_t_reg});
    assign room = (pc_reg < CW'(MAX_POINTS));

    // magnitudes of the deltas
    logic [DW-1:0] dmag [3];
    assign dmag[0] = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
    assign dmag[1] = dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);
    assign dmag[2] = dz_reg[DW-1] ? DW'(-dz_reg) : DW'(dz_reg);

    logic [66:0] len_sum, cr_sum;
    assign len_sum = 67'(sq_reg[0]) + 67'(sq_reg[1]) + 67'(sq_reg[2]);
    assign cr_sum  = 67'(crsq_reg[0]) + 67'(crsq_reg[1]) + 67'(crsq_reg[2]);

    // one root bit per cycle
    logic [37:0] r_acc, r_trial;
    logic        r_ok;
    assign r_acc   = {rem_reg, rad_reg[pgkd_pkg::RAD_W-1 -: 2]};
    assign r_trial = {2'b00, root_reg, 2'b01};
    assign r_ok    = (r_acc >= r_trial);

    // median bit match
    logic med_match;
    assign med_match = (((rd_len ^ pref_reg) & mask_reg) == '0) && ((rd_len & bsel_reg) == '0);

    // reduced vector components
    logic signed [15:0] vb [3];
    logic               red_busy;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vb[i] = red_neg_reg[i] ? -$signed({1'b0, red_mag_reg[i][14:0]})
                                   : $signed({1'b0, red_mag_reg[i][14:0]});
        end
    end
    assign red_busy = (red_mag_reg[0][DW-1:15] != '0) || (red_mag_reg[1][DW-1:15] != '0) ||
                      (red_mag_reg[2][DW-1:15] != '0);

    // squares of the cross product components
    logic signed [65:0] crsq_w [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            crsq_w[i] = cr_reg[i] * cr_reg[i];
        end
    end

    // cordic step and final angle
    logic signed [35:0] sx, sy;
    logic signed [27:0] at;
    logic signed [27:0] zc;
    logic [19:0]        zr;
    logic [15:0]        ang_calc;
    logic signed [35:0] c_mag;
    assign sx    = cx_reg >>> ci_reg;
    assign sy    = cy_reg >>> ci_reg;
    assign at    = $signed({6'b0, pgkd_pkg::atan_deg(ci_reg)});
    assign zc    = cz_reg[27] ? 28'sd0 : cz_reg;
    assign zr    = 20'((zc + 28'sd128) >>> 8);
    assign ang_calc = (zr > 20'(pgkd_pkg::ANGLE_MAX)) ? pgkd_pkg::ANGLE_MAX : zr[15:0];
    assign c_mag = $signed({2'b00, root_reg});

    // divider numerator and step
    logic [35:0] num_w;
    logic [21:0] d_acc;
    logic        d_ok;
    assign num_w = (36'(kthr_reg) << 18) + (36'(kthr_reg) << 17) + (36'(ang_reg) << 16)
                   + (36'(kthr_reg) << 2) + 36'(kthr_reg);
    assign d_acc = {drem_reg[20:0], dnum_reg[35]};
    assign d_ok  = (d_acc >= 22'(dden_reg));

    logic found;
    logic need_div;
    assign found    = (atime_reg > 32'sd0);
    assign need_div = found && !kind_reg && (kthr_reg != '0);

    logic [16:0] conf_out;
    assign conf_out = need_div ? ((dnum_reg > 36'(pgkd_pkg::CONF_ONE)) ? pgkd_pkg::CONF_ONE
                                                                        : dnum_reg[16:0])
                               : conf_reg;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kthr_reg      <= pgkd_pkg::KINK_THR_RST;
            gratio_reg    <= pgkd_pkg::GAP_RATIO_RST;
            minp_reg      <= pgkd_pkg::MIN_POINTS_RST;
            have_prev_reg <= 1'b0;
            pc_reg        <= '0;
            nseg_reg      <= '0;
            rcnt_reg      <= '0;
            dcnt_reg      <= '0;
            vld_reg       <= 1'b0;
            mv_reg        <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    pgkd_pkg::CFG_KINK_THR:   kthr_reg   <= cfg_wdata;
                    pgkd_pkg::CFG_GAP_RATIO:  gratio_reg <= cfg_wdata;
                    pgkd_pkg::CFG_MIN_POINTS: minp_reg   <= cfg_wdata[8:0];
                    default: ;
                endcase
            end
            if (cmd.load && room) begin
                have_prev_reg <= 1'b1;
                pc_reg        <= pc_reg + 1'b1;
            end
            if (cmd.store) begin
                nseg_reg <= nseg_reg + 1'b1;
            end
            if (cmd.path_clr) begin
                have_prev_reg <= 1'b0;
                pc_reg        <= '0;
                nseg_reg      <= '0;
            end
            if (cmd.root_len || cmd.root_cross) begin
                rcnt_reg <= 6'd34;
            end else if (rcnt_reg != '0) begin
                rcnt_reg <= rcnt_reg - 1'b1;
            end
            if (cmd.div_go) begin
                dcnt_reg <= 6'd36;
            end else if (dcnt_reg != '0) begin
                dcnt_reg <= dcnt_reg - 1'b1;
            end
            if (cmd.med_start) begin
                vld_reg <= 1'b0;
            end else if (cmd.med_scan) begin
                vld_reg <= (idx_reg != nseg_reg);
            end
            if (cmd.emit) begin
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        // point intake
        if (cmd.load) begin
            last_reg <= s_tlast;
            seg_reg  <= room && have_prev_reg && (dt > 33'sd0);
            if (room) begin
                dx_reg     <= $signed({in_x[31], in_x}) - $signed({prev_x_reg[31], prev_x_reg});
                dy_reg     <= $signed({in_y[31], in_y}) - $signed({prev_y_reg[31], prev_y_reg});
                dz_reg     <= $signed({in_z[31], in_z}) - $signed({prev_z_reg[31], prev_z_reg});
                ptime_reg  <= in_t;
                prev_x_reg <= in_x;
                prev_y_reg <= in_y;
                prev_z_reg <= in_z;
                prev_t_reg <= in_t;
            end
        end
        if (cmd.path_clr) begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            prev_z_reg <= '0;
            prev_t_reg <= '0;
        end
        if (cmd.sq) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= 65'(dmag[i] * dmag[i]);
            end
        end
        // square root
        if (cmd.root_len || cmd.root_cross) begin
            rad_reg  <= cmd.root_len ? 68'(len_sum) : 68'(cr_sum);
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (rcnt_reg != '0) begin
            rad_reg  <= {rad_reg[pgkd_pkg::RAD_W-3:0], 2'b00};
            rem_reg  <= r_ok ? 36'(r_acc - r_trial) : r_acc[35:0];
            root_reg <= {root_reg[LW-2:0], r_ok};
        end
        if (cmd.store && (nseg_reg == '0)) begin
            len0_reg <= root_reg;
        end
        // evaluation start
        if (cmd.eval_init) begin
            atime_reg <= '0;
            kind_reg  <= 1'b0;
            ang_reg   <= '0;
            rank_reg  <= nseg_reg >> 1;
            pref_reg  <= '0;
            mask_reg  <= '0;
            bsel_reg  <= {1'b1, {(LW-1){1'b0}}};
        end
        // median scan
        if (cmd.med_start) begin
            idx_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.med_scan) begin
            if (idx_reg != nseg_reg) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (vld_reg && med_match) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        if (cmd.med_bit) begin
            if (cnt_reg <= rank_reg) begin
                rank_reg <= rank_reg - cnt_reg;
                pref_reg <= pref_reg | bsel_reg;
            end
            mask_reg <= mask_reg | bsel_reg;
            bsel_reg <= bsel_reg >> 1;
        end
        if (cmd.thr_mul) begin
            thp_reg <= 50'(gratio_reg * pref_reg);
        end
        // scan index
        if (cmd.idx_zero) begin
            idx_reg <= '0;
        end else if (cmd.idx_one) begin
            idx_reg <= CW'(1);
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.gap_take) begin
            atime_reg <= $signed(rd_time);
            kind_reg  <= 1'b1;
            ang_reg   <= '0;
        end
        // vector reduction
        if (cmd.red_load) begin
            for (int i = 0; i < 3; i++) begin
                red_neg_reg[i] <= rd_d[i][DW-1];
                red_mag_reg[i] <= rd_d[i][DW-1] ? DW'(-rd_d[i]) : DW'(rd_d[i]);
            end
        end else if (cmd.red_run) begin
            for (int i = 0; i < 3; i++) begin
                red_mag_reg[i] <= red_mag_reg[i] >> 1;
            end
        end
        if (cmd.base_take) begin
            for (int i = 0; i < 3; i++) begin
                base_reg[i] <= vb[i];
            end
        end
        // dot and cross products
        if (cmd.kmul) begin
            for (int i = 0; i < 3; i++) begin
                pd_reg[i] <= base_reg[i] * vb[i];
            end
            pcr_reg[0] <= base_reg[1] * vb[2];
            pcr_reg[1] <= base_reg[2] * vb[1];
            pcr_reg[2] <= base_reg[2] * vb[0];
            pcr_reg[3] <= base_reg[0] * vb[2];
            pcr_reg[4] <= base_reg[0] * vb[1];
            pcr_reg[5] <= base_reg[1] * vb[0];
        end
        if (cmd.kdiff) begin
            dot_reg   <= 34'(pd_reg[0]) + 34'(pd_reg[1]) + 34'(pd_reg[2]);
            cr_reg[0] <= 33'(pcr_reg[0]) - 33'(pcr_reg[1]);
            cr_reg[1] <= 33'(pcr_reg[2]) - 33'(pcr_reg[3]);
            cr_reg[2] <= 33'(pcr_reg[4]) - 33'(pcr_reg[5]);
        end
        if (cmd.ksq) begin
            for (int i = 0; i < 3; i++) begin
                crsq_reg[i] <= crsq_w[i][64:0];
            end
        end
        // cordic vectoring
        if (cmd.cordic_init) begin
            ci_reg <= '0;
            if (dot_reg < 34'sd0) begin
                cx_reg <= c_mag;
                cy_reg <= -36'(dot_reg);
                cz_reg <= $signed(pgkd_pkg::Z_QUARTER);
            end else begin
                cx_reg <= 36'(dot_reg);
                cy_reg <= c_mag;
                cz_reg <= '0;
            end
        end else if (cmd.cordic_run) begin
            ci_reg <= ci_reg + 1'b1;
            if (cy_reg > 36'sd0) begin
                cx_reg <= cx_reg + sy;
                cy_reg <= cy_reg - sx;
                cz_reg <= cz_reg + at;
            end else begin
                cx_reg <= cx_reg - sy;
                cy_reg <= cy_reg + sx;
                cz_reg <= cz_reg - at;
            end
        end
        if (cmd.kink_eval && (ang_calc > kthr_reg) && (atime_reg == '0)) begin
            atime_reg <= $signed(rd_time);
            kind_reg  <= 1'b0;
            ang_reg   <= ang_calc;
        end
        // confidence
        if (cmd.conf_fixed) begin
            if (!found) begin
                conf_reg <= '0;
            end else if (kind_reg) begin
                conf_reg <= pgkd_pkg::GAP_CONF;
            end else begin
                conf_reg <= pgkd_pkg::CONF_ONE;
            end
        end
        if (cmd.div_go) begin
            dnum_reg <= num_w;
            drem_reg <= '0;
            dden_reg <= (20'(kthr_reg) << 3) + (20'(kthr_reg) << 1);
        end else if (dcnt_reg != '0) begin
            drem_reg <= d_ok ? (d_acc - 22'(dden_reg)) : d_acc;
            dnum_reg <= {dnum_reg[34:0], d_ok};
        end
        // result register
        if (cmd.emit) begin
            muser_reg <= {found & kind_reg, found};
            mdata_reg <= {7'd0, found ? conf_out : 17'd0, found ? ang_reg : 16'd0,
                          found ? atime_reg : 32'sd0};
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    // status
    assign sts.seg         = seg_reg;
    assign sts.last        = last_reg;
    assign sts.root_busy   = (rcnt_reg != '0);
    assign sts.eval_ok     = (MW'(pc_reg) >= MW'(minp_reg)) && (nseg_reg >= CW'(3)) &&
                             (len0_reg != '0);
    assign sts.scan_done   = (idx_reg == nseg_reg) && !vld_reg;
    assign sts.med_last    = bsel_reg[0];
    assign sts.gap_hit     = (50'({rd_len, 8'd0}) > thp_reg);
    assign sts.gap_tnz     = (rd_time != '0);
    assign sts.idx_last    = (idx_reg == (nseg_reg - 1'b1));
    assign sts.len_zero    = (rd_len == '0);
    assign sts.red_busy    = red_busy;
    assign sts.cordic_busy = (ci_reg != 5'(pgkd_pkg::ATAN_STEPS)) && (cy_reg != '0);
    assign sts.atime_set   = (atime_reg != '0);
    assign sts.need_div    = need_div;
    assign sts.div_busy    = (dcnt_reg != '0);
    assign sts.out_free    = !mv_reg || m_tready;
endmodule

>>> src/path_gap_and_kink_detector.sv
// top level of the path gap and kink detector
//
// channel  | direction | handshake                 | contents
// s_       | in        | s_tvalid/s_tready/s_tlast | one path point x, y, z, t; tlast ends the path
// m_       | out       | m_tvalid/m_tready         | one result per path
// cfg_     | in        | cfg_we                    | kink threshold, gap ratio, minimum point count
//
// a point that makes a segment also runs the bit serial square root for its length. at
// the end of a path the median is found one length bit per scan over the segments,
// then the gap scan runs and each kink test does reduce, products, square root and
// up to 22 cordic steps, and the confidence divide follows. synchronous active low
// reset clears the path and restores the register defaults; a result waiting on
// m_tready lets the next path's points enter, and only that path's end waits for the
// output register to free up
`timescale 1ns / 1ps
module path_gap_and_kink_detector #(
    parameter int MAX_POINTS = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // x[31:0], y[63:32], z[95:64], t[127:96]
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // flag_time[31:0], anomaly_angle[47:32], confidence[64:48]
    output logic [1:0]   m_tuser,   // found[0], anomaly_kind[1]
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [15:0]  cfg_wdata
);
    pgkd_pkg::cmd_t cmd;
    pgkd_pkg::sts_t sts;

    pgkd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pgkd_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef ASSERT_OFF
    // a result is only loaded into a free output register
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free) else $error("result loaded over a pending one");

    // the square root unit is never restarted while busy
    a_root_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.root_len || cmd.root_cross) |-> !sts.root_busy)
        else $error("square root restarted while busy");

    // a loaded result shows up on the output
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_tvalid) else $error("loaded result not presented");
`endif
endmodule

>>> sim/tb_top.sv
// self-checking testbench for the path gap and kink detector: directed table, then random paths
`timescale 1ns / 1ps
module tb_top;

    localparam logic [1:0] CFG_SPARE   = 2'd3;
    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         PATH_CAP    = 256;
    localparam int         SEG_LIMIT   = PATH_CAP - 1;
    localparam int         HOLD_CYCLES = 6000;
    localparam longint     ATAN_TAB [pgkd_pkg::ATAN_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2};

    typedef struct {
        logic [31:0] x, y, z, t;
        bit          last;
    } point_t;

    typedef struct {
        bit          found;
        bit          kind;
        logic [31:0] atime;
        logic [15:0] angle;
        logic [16:0] conf;
    } verdict_t;

    typedef struct {
        point_t pt;
        bit     none_found;
    } row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // x[31:0], y[63:32], z[95:64], t[127:96]
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;   // flag_time[31:0], anomaly_angle[47:32], confidence[64:48]
    logic [1:0]   m_tuser;   // found[0], anomaly_kind[1]
    logic         cfg_we;
    logic [1:0]   cfg_addr;
    logic [15:0]  cfg_wdata;

    verdict_t verdicts_due[$];
    row_t     path_table[$];
    int       errors;
    int       cycles;
    int       points_sent;
    bit       idle_on;
    bit       hold_req;

    // predictor copy of registers and path state
    logic [15:0] thr_q, ratio_q;
    logic [8:0]  minpts_q;
    longint      px, py, pz, ptime;
    bit          have_prev;
    int          pcount, scount;
    longint      sdx [SEG_LIMIT];
    longint      sdy [SEG_LIMIT];
    longint      sdz [SEG_LIMIT];
    longint      stime [SEG_LIMIT];
    logic [33:0] slen [SEG_LIMIT];

    path_gap_and_kink_detector dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // floor square root of a value below 2^68
    function automatic logic [33:0] isqrt68(input logic [67:0] v);
        logic [33:0] r;
        logic [67:0] c;
        int b;
        r = '0;
        for (b = 33; b >= 0; b--) begin
            c = {34'd0, r | (34'd1 << b)};
            if (c * c <= v) r = c[33:0];
        end
        return r;
    endfunction

    function automatic logic [67:0] square_mag(input longint a);
        logic [67:0] m;
        m = (a < 0) ? 68'(-a) : 68'(a);
        return m * m;
    endfunction

    // scale a vector so its largest magnitude is below 2^15
    function automatic void shrink(inout longint a, inout longint b, inout longint c);
        longint ma, mb, mc, top;
        int k;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        mc = (c < 0) ? -c : c;
        top = ma;
        if (mb > top) top = mb;
        if (mc > top) top = mc;
        k = 0;
        while ((top >>> k) >= 32768) k++;
        a = (a < 0) ? -(ma >>> k) : (ma >>> k);
        b = (b < 0) ? -(mb >>> k) : (mb >>> k);
        c = (c < 0) ? -(mc >>> k) : (mc >>> k);
    endfunction

    // angle between two segments in Q8.8 degrees by vectoring cordic
    function automatic logic [15:0] seg_angle(input longint ax, input longint ay,
                                              input longint az, input longint bx,
                                              input longint by, input longint bz);
        longint x, y, z, cx, cy, cz, sx, sy, nx;
        logic [63:0] c2;
        int i;
        shrink(ax, ay, az);
        shrink(bx, by, bz);
        x = ax * bx + ay * by + az * bz;
        cx = ay * bz - az * by;
        cy = az * bx - ax * bz;
        cz = ax * by - ay * bx;
        c2 = 64'(cx * cx) + 64'(cy * cy) + 64'(cz * cz);
        y = longint'(isqrt68({4'd0, c2}));
        z = 0;
        if (x < 0) begin
            nx = y;
            y = -x;
            x = nx;
            z = 90 * 65536;
        end
        for (i = 0; i < pgkd_pkg::ATAN_STEPS && y != 0; i++) begin
            sx = x >>> i;
            sy = y >>> i;
            if (y > 0) begin
                x += sy;
                y -= sx;
                z += ATAN_TAB[i];
            end else begin
                x -= sy;
                y += sx;
                z -= ATAN_TAB[i];
            end
        end
        if (z < 0) z = 0;
        z = (z + 128) >>> 8;
        if (z > 46080) z = 46080;
        return z[15:0];
    endfunction

    // fold one point into the path; returns 1 with the verdict on the final point
    function automatic bit advance_path(input point_t p, output verdict_t v);
        longint x, y, z, t, atime, num, den, q;
        int n, i;
        logic [15:0] a, ang;
        bit kind, found;
        logic [33:0] med;
        logic [33:0] srt[$];
        x = $signed(p.x);
        y = $signed(p.y);
        z = $signed(p.z);
        t = $signed(p.t);
        v.found = 0;
        v.kind = 0;
        v.atime = '0;
        v.angle = '0;
        v.conf = '0;
        if (pcount < PATH_CAP) begin
            if (have_prev && t - ptime > 0 && scount < SEG_LIMIT) begin
                sdx[scount] = x - px;
                sdy[scount] = y - py;
                sdz[scount] = z - pz;
                stime[scount] = t;
                slen[scount] = isqrt68(square_mag(x - px) + square_mag(y - py)
                                       + square_mag(z - pz));
                scount++;
            end
            px = x;
            py = y;
            pz = z;
            ptime = t;
            have_prev = 1;
            pcount++;
        end
        if (!p.last) return 0;

        atime = 0;
        kind = 0;
        ang = '0;
        found = 0;
        n = scount;
        if (pcount >= minpts_q && n >= 3 && slen[0] != 0) begin
            for (i = 0; i < n; i++) srt = {srt, slen[i]};
            srt.sort();
            med = srt[n / 2];
            // gap scan
            for (i = 1; i < n; i++) begin
                if (atime == 0 && 64'(slen[i]) * 64'd256 > 64'(ratio_q) * 64'(med)) begin
                    atime = stime[i];
                    kind = 1;
                    break;
                end
            end
            // kink scan against the base segment
            for (i = 1; i < n; i++) begin
                if (slen[i] == 0) continue;
                a = seg_angle(sdx[0], sdy[0], sdz[0], sdx[i], sdy[i], sdz[i]);
                if (a > thr_q && atime == 0) begin
                    atime = stime[i];
                    ang = a;
                    kind = 0;
                end
            end
            found = atime > 0;
        end
        if (found) begin
            v.found = 1;
            v.kind = kind;
            v.atime = atime[31:0];
            v.angle = kind ? 16'd0 : ang;
            if (kind) v.conf = 17'd58982;
            else if (thr_q == 0) v.conf = 17'd65536;
            else begin
                num = 2 * (196608 * longint'(thr_q) + 32768 * longint'(ang))
                      + 5 * longint'(thr_q);
                den = 10 * longint'(thr_q);
                q = num / den;
                v.conf = (q > 65536) ? 17'd65536 : q[16:0];
            end
        end
        px = 0;
        py = 0;
        pz = 0;
        ptime = 0;
        have_prev = 0;
        pcount = 0;
        scount = 0;
        return 1;
    endfunction

    // offer one point, then draw the gap before the next one
    task automatic send_point(input point_t p, input bit none_found);
        verdict_t pv;
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {p.t, p.z, p.y, p.x};
        s_tlast <= p.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        points_sent++;
        if (advance_path(p, pv)) begin
            if (none_found) begin
                pv.found = 0;
                pv.kind = 0;
                pv.atime = '0;
                pv.angle = '0;
                pv.conf = '0;
            end
            verdicts_due = {verdicts_due, pv};
        end
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // pause the sender until every verdict has come back
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdicts_due.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            pgkd_pkg::CFG_KINK_THR:   thr_q = val;
            pgkd_pkg::CFG_GAP_RATIO:  ratio_q = val;
            pgkd_pkg::CFG_MIN_POINTS: minpts_q = val[8:0];
            default: ;
        endcase
    endtask

    task automatic add_row(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                           input logic [31:0] t, input bit last, input bit none_found);
        row_t r;
        r.pt.x = x;
        r.pt.y = y;
        r.pt.z = z;
        r.pt.t = t;
        r.pt.last = last;
        r.none_found = none_found;
        path_table = {path_table, r};
    endtask

    // random path: a line with random content and at most one disturbance
    task automatic run_path(input int npts);
        point_t p;
        logic [31:0] cx, cy, cz, ct;
        int sx, sy, sz, tmp, dt, spot, twist, i;
        if ($urandom_range(0, 3) == 0) begin
            cx = $urandom;
            cy = $urandom;
            cz = $urandom;
        end else begin
            cx = int'($urandom_range(0, 2 ** 24)) - 2 ** 23;
            cy = int'($urandom_range(0, 2 ** 24)) - 2 ** 23;
            cz = int'($urandom_range(0, 2 ** 24)) - 2 ** 23;
        end
        ct = ($urandom_range(0, 3) == 0) ? $urandom
                                         : int'($urandom_range(0, 8 * 65536)) - 4 * 65536;
        sx = int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
        sy = int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
        sz = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
        spot = $urandom_range(1, (npts > 1) ? npts - 1 : 1);
        twist = $urandom_range(0, 4);
        for (i = 0; i < npts; i++) begin
            dt = ($urandom_range(0, 15) == 0) ? -int'($urandom_range(0, 65536))
                                              : int'($urandom_range(1, 131072));
            ct = ct + dt;
            p.x = cx + $urandom_range(0, 255);
            p.y = cy + $urandom_range(0, 255);
            p.z = cz;
            p.t = ct;
            p.last = (i == npts - 1);
            if (i == spot) begin
                case (twist)
                    1: begin
                        // jump
                        tmp = $urandom_range(2, 40);
                        cx = cx + sx * tmp;
                        cy = cy + sy * tmp;
                        p.x = cx;
                        p.y = cy;
                    end
                    2: begin
                        // turn
                        tmp = sx;
                        sx = -sy;
                        sy = tmp;
                        sz = int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
                    end
                    3: begin
                        p.x = $urandom;
                        p.y = $urandom;
                        p.z = $urandom;
                        p.t = $urandom;
                    end
                    4: begin
                        // repeated point
                        p.x = cx;
                        p.y = cy;
                    end
                    default: ;
                endcase
            end
            send_point(p, 1'b0);
            cx = cx + sx;
            cy = cy + sy;
            cz = cz + sz;
        end
    endtask

    // result checker
    always @(posedge aclk) begin : check_result
        verdict_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (verdicts_due.size() == 0) begin
                $error("result with no request pending");
                errors++;
            end else begin
                e = verdicts_due.pop_front();
                if (m_tuser[0] !== e.found) begin
                    $error("found: expected %0d, got %0d", e.found, m_tuser[0]);
                    errors++;
                end
                if (m_tuser[1] !== e.kind) begin
                    $error("anomaly_kind: expected %0d, got %0d", e.kind, m_tuser[1]);
                    errors++;
                end
                if (m_tdata[31:0] !== e.atime) begin
                    $error("flag_time: expected %0h, got %0h", e.atime, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[47:32] !== e.angle) begin
                    $error("anomaly_angle: expected %0d, got %0d", e.angle, m_tdata[47:32]);
                    errors++;
                end
                if (m_tdata[64:48] !== e.conf) begin
                    $error("confidence: expected %0d, got %0d", e.conf, m_tdata[64:48]);
                    errors++;
                end
            end
        end
    end

    // run time limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: random ready gaps plus one long hold-off
    initial begin : result_side
        int n;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 0;
            end
            n = idle_on ? $urandom_range(0, 7) : 0;
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // stimulus
    initial begin : stimulus
        int i, ph, target;
        errors = 0;
        cycles = 0;
        points_sent = 0;
        idle_on = 1;
        hold_req = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        thr_q = pgkd_pkg::KINK_THR_RST;
        ratio_q = pgkd_pkg::GAP_RATIO_RST;
        minpts_q = pgkd_pkg::MIN_POINTS_RST;
        have_prev = 0;
        pcount = 0;
        scount = 0;
        px = 0;
        py = 0;
        pz = 0;
        ptime = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single point path
        add_row(32'd0, 32'd0, 32'd0, 32'd0, 1, 1);
        // coordinate extremes, too few points
        add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 1);
        add_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 1);
        add_row(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000, 1, 1);
        // zero length base segment
        for (i = 0; i < 8; i++)
            add_row((i == 0) ? 0 : (i - 1) * 65536, 32'd0, 32'd0, i * 65536, i == 7, 1);
        // gap, with one time step that goes backwards
        for (i = 0; i < 8; i++)
            add_row(i * 65536 + ((i >= 6) ? 20 * 65536 : 0), 32'd0, 32'd0,
                    ((i == 3) ? 1 : i) * 65536, i == 7, 0);
        // right angle turn
        for (i = 0; i < 8; i++)
            add_row(((i < 5) ? i : 4) * 65536, ((i < 5) ? 0 : i - 4) * 65536, 32'd0,
                    (i + 1) * 65536, i == 7, 0);
        foreach (path_table[i]) send_point(path_table[i].pt, path_table[i].none_found);
        drain();

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(pgkd_pkg::CFG_KINK_THR, 16'd0);
                    write_reg(pgkd_pkg::CFG_GAP_RATIO, 16'd0);
                    write_reg(pgkd_pkg::CFG_MIN_POINTS, 16'd0);
                    write_reg(CFG_SPARE, 16'hffff);
                    target = 150;
                end
                1: begin
                    write_reg(pgkd_pkg::CFG_KINK_THR, 16'd46080);
                    write_reg(pgkd_pkg::CFG_GAP_RATIO, 16'd65535);
                    write_reg(pgkd_pkg::CFG_MIN_POINTS, 16'd3);
                    hold_req = 1;
                    target = 270;
                end
                2: begin
                    write_reg(pgkd_pkg::CFG_KINK_THR, 16'($urandom_range(0, 46080)));
                    write_reg(pgkd_pkg::CFG_GAP_RATIO, 16'($urandom_range(256, 4096)));
                    write_reg(pgkd_pkg::CFG_MIN_POINTS, 16'd256);
                    target = 540;
                end
                3: begin
                    write_reg(pgkd_pkg::CFG_KINK_THR, 16'd256);
                    write_reg(pgkd_pkg::CFG_GAP_RATIO, 16'd512);
                    write_reg(pgkd_pkg::CFG_MIN_POINTS, 16'd4);
                    target = 610;
                end
                default: begin
                    write_reg(pgkd_pkg::CFG_KINK_THR, 16'($urandom_range(0, 3840)));
                    write_reg(pgkd_pkg::CFG_GAP_RATIO, 16'($urandom));
                    write_reg(pgkd_pkg::CFG_MIN_POINTS, 16'($urandom_range(0, 12)));
                    target = 650;
                end
            endcase
            cfg_we <= 1'b0;
            // overlong path, more points than the block keeps
            if (ph == 2) run_path(262);
            while (points_sent < target) begin
                idle_on = ($urandom_range(0, 3) != 0);
                run_path(($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(2, 12));
            end
            idle_on = 1;
            drain();
        end

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
